// File: rtl/cbsi_pkg.sv
// Package for the scanline IRQ bank switcher: item and result structs,
// job records passed from front to back, address and command codes.
// No dependencies.
package cbsi_pkg;

  // Input item and result item
  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
    logic [8:0]  scanline;
    logic        rendering_on;
  } in_item_t;

  typedef struct packed {
    logic        bank_valid;
    logic        bank_is_pattern;
    logic [2:0]  bank_slot;
    logic [10:0] bank_page;
    logic        irq_request;
    logic        last_result;
  } out_item_t;

  // Configuration register indexes
  localparam logic CFG_PRG_COUNT = 1'b0;
  localparam logic CFG_CHR_COUNT = 1'b1;

  typedef struct packed {
    logic [7:0] prg_count;
    logic [7:0] chr_count;
  } cfg_t;

  // Opcodes
  localparam logic [1:0] OP_MAPPER = 2'd0;
  localparam logic [1:0] OP_EXPAN  = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_INIT   = 2'd3;

  // Mapper register addresses
  localparam logic [15:0] ADDR_CMD      = 16'h8000;
  localparam logic [15:0] ADDR_BANK     = 16'h8001;
  localparam logic [15:0] ADDR_IRQ_CNT  = 16'hC000;
  localparam logic [15:0] ADDR_IRQ_LAT  = 16'hC001;
  localparam logic [15:0] ADDR_IRQ_OFF  = 16'hE000;
  localparam logic [15:0] ADDR_IRQ_ON   = 16'hE001;
  localparam logic [7:0]  EXPAN_PAGE    = 8'h41;

  // Bank commands
  localparam logic [7:0] CMD_CHR01 = 8'h40;
  localparam logic [7:0] CMD_CHR23 = 8'h41;
  localparam logic [7:0] CMD_CHR4  = 8'h42;
  localparam logic [7:0] CMD_CHR5  = 8'h43;
  localparam logic [7:0] CMD_CHR6  = 8'h44;
  localparam logic [7:0] CMD_CHR7  = 8'h45;
  localparam logic [7:0] CMD_PRG2  = 8'h46;
  localparam logic [7:0] CMD_PRG1  = 8'h47;

  localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

  // Work handed from front to back
  typedef enum logic [2:0] {
    JOB_CHR_PAIR,
    JOB_CHR_ONE,
    JOB_PRG_ONE,
    JOB_PRG_GROUP,
    JOB_INIT,
    JOB_IRQ
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [2:0] slot;
    logic [7:0] data;
  } job_t;

  // Job queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } jq_stat_t;

endpackage

// File: rtl/cbsi_front.sv
// Front end: configuration registers, command and IRQ counter state,
// decode of each accepted item into a job. Depends on cbsi_pkg.
module cbsi_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              accept_i,
  input  cbsi_pkg::in_item_t item_i,
  output cbsi_pkg::cfg_t    cfg_o,
  output logic              job_push_o,
  output cbsi_pkg::job_t    job_o
);
  import cbsi_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] lat_q, lat_d;
  logic       en_q, en_d;
  logic       prg_ok, chr_ok;
  logic [7:0] cnt_dec;

  assign prg_ok  = (cfg_q.prg_count != 8'd0);
  assign chr_ok  = (cfg_q.chr_count != 8'd0);
  assign cnt_dec = cnt_q - 8'd1;
  assign cfg_o   = cfg_q;

  // Decode and state update
  always_comb begin
    cfg_d      = cfg_q;
    cmd_d      = cmd_q;
    cnt_d      = cnt_q;
    lat_d      = lat_q;
    en_d       = en_q;
    job_push_o = 1'b0;
    job_o.kind = JOB_IRQ;
    job_o.slot = 3'd0;
    job_o.data = item_i.bus_data;

    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_PRG_COUNT) cfg_d.prg_count = cfg_data_i;
      else                            cfg_d.chr_count = cfg_data_i;
    end

    if (accept_i) begin
      unique case (item_i.opcode)
        OP_MAPPER: begin
          unique case (item_i.bus_address)
            ADDR_CMD:     cmd_d = item_i.bus_data;
            ADDR_IRQ_CNT: cnt_d = item_i.bus_data;
            ADDR_IRQ_LAT: lat_d = item_i.bus_data;
            ADDR_IRQ_OFF: en_d  = 1'b0;
            ADDR_IRQ_ON:  en_d  = 1'b1;
            ADDR_BANK: begin
              unique case (cmd_q)
                CMD_CHR01, CMD_CHR23: begin
                  // pair starts at slot 0 or 2
                  job_push_o = chr_ok;
                  job_o.kind = JOB_CHR_PAIR;
                  job_o.slot = {1'b0, cmd_q[0], 1'b0};
                end
                CMD_CHR4, CMD_CHR5, CMD_CHR6, CMD_CHR7: begin
                  job_push_o = chr_ok;
                  job_o.kind = JOB_CHR_ONE;
                  job_o.slot = cmd_q[2:0] + 3'd2;
                end
                CMD_PRG2: begin
                  job_push_o = prg_ok;
                  job_o.kind = JOB_PRG_ONE;
                  job_o.slot = 3'd2;
                end
                CMD_PRG1: begin
                  job_push_o = prg_ok;
                  job_o.kind = JOB_PRG_ONE;
                  job_o.slot = 3'd1;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        OP_EXPAN: begin
          if (item_i.bus_address[15:8] == EXPAN_PAGE) begin
            job_push_o = prg_ok;
            job_o.kind = JOB_PRG_GROUP;
          end
        end
        OP_TICK: begin
          if (en_q && item_i.rendering_on &&
              (item_i.scanline <= LAST_VISIBLE_LINE)) begin
            if (cnt_dec == 8'd0) begin
              cnt_d      = lat_q;
              job_push_o = 1'b1;
              job_o.kind = JOB_IRQ;
            end else begin
              cnt_d = cnt_dec;
            end
          end
        end
        OP_INIT: begin
          cnt_d      = 8'd0;
          lat_d      = 8'd0;
          en_d       = 1'b0;
          job_push_o = prg_ok || chr_ok;
          job_o.kind = JOB_INIT;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prg_count <= 8'd2;
      cfg_q.chr_count <= 8'd0;
      cmd_q           <= 8'd0;
      cnt_q           <= 8'd0;
      lat_q           <= 8'd0;
      en_q            <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      cmd_q <= cmd_d;
      cnt_q <= cnt_d;
      lat_q <= lat_d;
      en_q  <= en_d;
    end
  end

endmodule

// File: rtl/cbsi_jobq.sv
// Two-entry job queue between front and back.
// Depends on cbsi_pkg.
module cbsi_jobq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cbsi_pkg::job_t    job_i,
  input  logic              pop_i,
  output cbsi_pkg::job_t    job_o,
  output cbsi_pkg::jq_stat_t stat_o
);
  import cbsi_pkg::*;

  job_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign job_o        = mem_q[rptr_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= job_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/cbsi_back.sv
// Back end: expands a job into its results, runs the bit-serial page
// remainder unit and holds the output register. Depends on cbsi_pkg.
module cbsi_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cbsi_pkg::cfg_t      cfg_i,
  input  cbsi_pkg::job_t      job_i,
  input  cbsi_pkg::jq_stat_t  jq_i,
  output logic                jq_pop_o,
  output logic                empty,
  input  logic                pop,
  output cbsi_pkg::out_item_t out_item_o
);
  import cbsi_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_STEP, S_DIV, S_OUT} state_e;

  state_e     state_q;
  job_t       job_q;
  logic [3:0] idx_q;
  logic [7:0] dvd_q;
  logic [7:0] rem_q;
  logic [2:0] bit_q;
  logic [2:0] low_q;
  logic       chr_q;
  logic [2:0] slot_q;
  logic       last_q;
  out_item_t  pend_q;
  out_item_t  res_q;
  logic       res_vld_q;

  // Per-step result description
  logic       s_chr, s_mod, s_irq, s_last;
  logic [2:0] s_slot;
  logic [8:0] s_val;
  logic [10:0] s_page;
  logic [3:0] idx_m4;
  logic [8:0] prg_n;

  assign idx_m4 = idx_q - 4'd4;
  assign prg_n  = {cfg_i.prg_count, 1'b0};

  always_comb begin
    s_chr  = 1'b0;
    s_mod  = 1'b1;
    s_irq  = 1'b0;
    s_last = 1'b1;
    s_slot = job_q.slot;
    s_val  = {1'b0, job_q.data};
    s_page = 11'd0;
    unique case (job_q.kind)
      JOB_CHR_PAIR: begin
        s_chr  = 1'b1;
        s_slot = job_q.slot + {2'b00, idx_q[0]};
        s_val  = {1'b0, job_q.data} + {8'd0, idx_q[0]};
        s_last = idx_q[0];
      end
      JOB_CHR_ONE: s_chr = 1'b1;
      JOB_PRG_ONE: ;
      JOB_PRG_GROUP: begin
        s_slot = {1'b0, idx_q[1:0]};
        s_val  = {5'd0, job_q.data[5:4], idx_q[1:0]};
        s_last = (idx_q[1:0] == 2'd3);
      end
      JOB_INIT: begin
        s_mod = 1'b0;
        if (!idx_q[3] && !idx_q[2]) begin
          s_slot = {1'b0, idx_q[1:0]};
          s_last = (idx_q[1:0] == 2'd3) && (cfg_i.chr_count == 8'd0);
          case (idx_q[1:0])
            2'd0:    s_page = 11'd0;
            2'd1:    s_page = 11'd1;
            2'd2:    s_page = {2'b00, prg_n - 9'd2};
            default: s_page = {2'b00, prg_n - 9'd1};
          endcase
        end else begin
          s_chr  = 1'b1;
          s_slot = idx_m4[2:0];
          s_page = {8'd0, idx_m4[2:0]};
          s_last = (idx_q == 4'd11);
        end
      end
      JOB_IRQ: begin
        s_mod  = 1'b0;
        s_irq  = 1'b1;
        s_slot = 3'd0;
      end
      default: ;
    endcase
  end

  // Remainder step: shift in one dividend bit, subtract if it fits
  logic [7:0] divisor;
  logic [8:0] trial;
  logic [7:0] rem_nx;
  logic [10:0] div_page;

  assign divisor  = chr_q ? cfg_i.chr_count : cfg_i.prg_count;
  assign trial    = {rem_q, dvd_q[7]};
  assign rem_nx   = (trial >= {1'b0, divisor}) ? 8'(trial - {1'b0, divisor})
                                              : trial[7:0];
  assign div_page = chr_q ? {rem_nx, low_q} : {2'b00, rem_nx, low_q[0]};

  logic out_free;
  logic res_load;
  assign out_free   = !res_vld_q || pop;
  assign res_load   = (state_q == S_OUT) && out_free;
  assign jq_pop_o   = (state_q == S_IDLE) && !jq_i.empty;
  assign empty      = !res_vld_q;
  assign out_item_o = res_q;

  // Sequencer, divider registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      res_vld_q <= 1'b0;
      idx_q     <= 4'd0;
      bit_q     <= 3'd0;
    end else begin
      // output valid: set on load, cleared when taken
      if (res_load)              res_vld_q <= 1'b1;
      else if (pop && res_vld_q) res_vld_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (!jq_i.empty) begin
            job_q   <= job_i;
            idx_q   <= ((job_i.kind == JOB_INIT) && (cfg_i.prg_count == 8'd0))
                       ? 4'd4 : 4'd0;
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          slot_q <= s_slot;
          chr_q  <= s_chr;
          last_q <= s_last;
          if (s_mod) begin
            dvd_q   <= s_chr ? {2'b00, s_val[8:3]} : {1'b0, s_val[7:1]};
            low_q   <= s_val[2:0];
            rem_q   <= 8'd0;
            bit_q   <= 3'd0;
            state_q <= S_DIV;
          end else begin
            pend_q.bank_valid      <= !s_irq;
            pend_q.bank_is_pattern <= s_chr;
            pend_q.bank_slot       <= s_slot;
            pend_q.bank_page       <= s_page;
            pend_q.irq_request     <= s_irq;
            pend_q.last_result     <= s_last;
            state_q                <= S_OUT;
          end
        end
        S_DIV: begin
          rem_q <= rem_nx;
          dvd_q <= {dvd_q[6:0], 1'b0};
          bit_q <= bit_q + 3'd1;
          if (bit_q == 3'd7) begin
            pend_q.bank_valid      <= 1'b1;
            pend_q.bank_is_pattern <= chr_q;
            pend_q.bank_slot       <= slot_q;
            pend_q.bank_page       <= div_page;
            pend_q.irq_request     <= 1'b0;
            pend_q.last_result     <= last_q;
            state_q                <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            res_q   <= pend_q;
            idx_q   <= idx_q + 4'd1;
            state_q <= pend_q.last_result ? S_IDLE : S_STEP;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/cartridge_bank_switch_scanline_irq_core.sv
// Top level of the scanline IRQ cartridge bank switcher: front decode,
// job queue and back sequencer. Depends on cbsi_pkg and the cbsi_* modules.
//
// Items enter through push/full and results leave through empty/pop, in
// order. The front takes one item per cycle while the two-entry job queue
// has room; items that cause no result (register writes, ticks without an
// interrupt) push no job. Each bank result that needs a page remainder
// passes through the back end in a setup step, eight steps of the shared
// bit-serial remainder unit and an output step; init pages and the IRQ
// result take a setup step and an output step only. Configuration is
// written through cfg_we_i/cfg_idx_i/cfg_data_i and is registered before
// it takes effect; write it only while the block is idle.
module cartridge_bank_switch_scanline_irq_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                push,
  output logic                full,
  input  cbsi_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output cbsi_pkg::out_item_t out_item_o
);
  import cbsi_pkg::*;

  cfg_t     cfg;
  logic     accept;
  logic     job_push;
  job_t     job_in;
  job_t     job_head;
  logic     job_pop;
  jq_stat_t jq_stat;

  assign full   = jq_stat.full;
  assign accept = push && !jq_stat.full;

  cbsi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .cfg_o      (cfg),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  cbsi_jobq u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .job_i  (job_in),
    .pop_i  (job_pop),
    .job_o  (job_head),
    .stat_o (jq_stat)
  );

  cbsi_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .job_i      (job_head),
    .jq_i       (jq_stat),
    .jq_pop_o   (job_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

// File: rtl/cbsi_checker.sv
// Port-level checks for the bank switcher core, attached by bind.
// Depends on cbsi_pkg and cartridge_bank_switch_scanline_irq_core.
module cbsi_port_props (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input logic                pop,
  input cbsi_pkg::out_item_t out_item_o
);
  import cbsi_pkg::*;

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("result changed while waiting");

  // An IRQ result carries no bank and ends its item
  a_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.irq_request) |->
      (!out_item_o.bank_valid && out_item_o.last_result &&
       out_item_o.bank_page == 11'd0 && out_item_o.bank_slot == 3'd0))
    else $error("malformed IRQ result");

  // Every result is either a bank or an IRQ
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.bank_valid != out_item_o.irq_request))
    else $error("result is neither bank nor IRQ");

  // Program slots are 0 to 3
  a_prg_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.bank_valid && !out_item_o.bank_is_pattern) |->
      !out_item_o.bank_slot[2])
    else $error("program slot out of range");

endmodule

bind cartridge_bank_switch_scanline_irq_core cbsi_port_props u_cbsi_port_props (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);
